[src/ftc_pkg.sv]
// Shared types and constants of the six-axis force/torque converter.
// No dependencies; compile first.
package ftc_pkg;

  localparam int GAUGES          = 6;
  localparam int AXES_DEF        = 6;
  localparam int COEF_FRAC_DEF   = 24;

  localparam int OpW    = 2;
  localparam int IdxW   = 6;
  localparam int GaugeW = 16;
  localparam int CoefW  = 32;
  localparam int ResW   = 32;
  localparam int ProdW  = CoefW + GaugeW;

  localparam logic signed [ResW-1:0] ResMax = {1'b0, {(ResW-1){1'b1}}};
  localparam logic signed [ResW-1:0] ResMin = {1'b1, {(ResW-1){1'b0}}};

  typedef enum logic [OpW-1:0] {
    OP_LOAD    = 2'd0,
    OP_CONVERT = 2'd1,
    OP_REARM   = 2'd2
  } opcode_e;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
    logic res_en;
  } ftc_adv_t;

endpackage

[src/ftc_if.sv]
// Valid/ready channels of the converter: command words in, wrench words out.
// Depends on ftc_pkg.
interface ftc_in_if import ftc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           opcode;
  logic [IdxW-1:0]          coef_index;
  logic signed [CoefW-1:0]  coef_value;
  logic signed [GaugeW-1:0] gauge_0;
  logic signed [GaugeW-1:0] gauge_1;
  logic signed [GaugeW-1:0] gauge_2;
  logic signed [GaugeW-1:0] gauge_3;
  logic signed [GaugeW-1:0] gauge_4;
  logic signed [GaugeW-1:0] gauge_5;

  modport source (output valid, opcode, coef_index, coef_value,
                  gauge_0, gauge_1, gauge_2, gauge_3, gauge_4, gauge_5,
                  input ready);
  modport sink (input valid, opcode, coef_index, coef_value,
                gauge_0, gauge_1, gauge_2, gauge_3, gauge_4, gauge_5,
                output ready);
endinterface

interface ftc_out_if import ftc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ResW-1:0] force_x;
  logic signed [ResW-1:0] force_y;
  logic signed [ResW-1:0] force_z;
  logic signed [ResW-1:0] torque_x;
  logic signed [ResW-1:0] torque_y;
  logic signed [ResW-1:0] torque_z;

  modport source (output valid, force_x, force_y, force_z,
                  torque_x, torque_y, torque_z, input ready);
  modport sink (input valid, force_x, force_y, force_z,
                torque_x, torque_y, torque_z, output ready);
endinterface

[src/six_axis_force_torque_converter.sv]
// Six-axis force/torque converter: bias capture, coefficient table and
// per-axis datapath. Depends on ftc_pkg, ftc_in_if, ftc_out_if and ftc_row.
//
// Takes one word per cycle while ready is high. A load word writes one
// coefficient, a rearm word makes the next sample the new bias, and a
// convert word yields one wrench word: products, row sum, then rescale and
// saturation each sit behind a register. Load and rearm words give no
// result. Empty stages close up under output backpressure, so ready drops
// only when all three stages hold a sample.
module six_axis_force_torque_converter import ftc_pkg::*; #(
  parameter int AXES               = AXES_DEF,
  parameter int COEF_FRACTION_BITS = COEF_FRAC_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ftc_in_if.sink    in_i,
  ftc_out_if.source out_o
);

  localparam int TableSize = AXES * AXES;
  localparam int NUse      = (AXES < GAUGES) ? AXES : GAUGES;

  logic signed [CoefW-1:0]  coef_q [TableSize];
  logic [GaugeW-1:0]        bias_q [GAUGES];
  logic                     pending_q;
  logic signed [GaugeW-1:0] gauge [GAUGES];
  logic signed [GaugeW-1:0] diff [NUse];
  logic signed [ResW-1:0]   res [GAUGES];
  logic                     prod_valid_q, sum_valid_q, res_valid_q;
  logic                     accept, is_load, is_convert, is_rearm;
  ftc_adv_t                 adv;

  assign gauge[0] = in_i.gauge_0;
  assign gauge[1] = in_i.gauge_1;
  assign gauge[2] = in_i.gauge_2;
  assign gauge[3] = in_i.gauge_3;
  assign gauge[4] = in_i.gauge_4;
  assign gauge[5] = in_i.gauge_5;

  assign adv.res_en  = !res_valid_q || out_o.ready;
  assign adv.sum_en  = !sum_valid_q || adv.res_en;
  assign adv.prod_en = !prod_valid_q || adv.sum_en;

  assign in_i.ready = adv.prod_en;
  assign accept     = in_i.valid && in_i.ready;
  assign is_load    = accept && (in_i.opcode == OP_LOAD);
  assign is_convert = accept && (in_i.opcode == OP_CONVERT);
  assign is_rearm   = accept && (in_i.opcode == OP_REARM);

  for (genvar k = 0; k < TableSize; k++) begin : g_coef
    always_ff @(posedge clk_i) begin
      if (is_load && (in_i.coef_index == IdxW'(k))) begin
        coef_q[k] <= in_i.coef_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b1;
      for (int c = 0; c < GAUGES; c++) begin
        bias_q[c] <= '0;
      end
    end else if (is_rearm) begin
      pending_q <= 1'b1;
    end else if (is_convert && pending_q) begin
      pending_q <= 1'b0;
      for (int c = 0; c < GAUGES; c++) begin
        bias_q[c] <= gauge[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUse; c++) begin
      diff[c] = pending_q ? '0 : gauge[c] - bias_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (adv.prod_en) begin
        prod_valid_q <= is_convert;
      end
      if (adv.sum_en) begin
        sum_valid_q <= prod_valid_q;
      end
      if (adv.res_en) begin
        res_valid_q <= sum_valid_q;
      end
    end
  end

  for (genvar r = 0; r < GAUGES; r++) begin : g_axis
    if (r < NUse) begin : g_row
      logic signed [CoefW-1:0] coef_row [NUse];
      for (genvar c = 0; c < NUse; c++) begin : g_col
        assign coef_row[c] = coef_q[r * AXES + c];
      end
      ftc_row #(
        .NCOL (NUse),
        .FRAC (COEF_FRACTION_BITS)
      ) u_row (
        .clk_i  (clk_i),
        .adv_i  (adv),
        .coef_i (coef_row),
        .diff_i (diff),
        .res_o  (res[r])
      );
    end else begin : g_zero
      assign res[r] = '0;
    end
  end

  assign out_o.valid    = res_valid_q;
  assign out_o.force_x  = res[0];
  assign out_o.force_y  = res[1];
  assign out_o.force_z  = res[2];
  assign out_o.torque_x = res[3];
  assign out_o.torque_y = res[4];
  assign out_o.torque_z = res[5];

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (prod_valid_q && sum_valid_q && res_valid_q))
    else $error("input stalled with an empty stage");

  a_res_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(sum_valid_q))
    else $error("result word without a row sum behind it");

  a_bias_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_convert |=> !pending_q)
    else $error("bias capture still armed after a convert word");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_rearm |=> pending_q)
    else $error("rearm word did not arm bias capture");

endmodule

[src/ftc_row.sv]
// One output axis: registered products, registered row sum, Q16.16 rescale
// and saturation into the result register. Depends on ftc_pkg.
module ftc_row import ftc_pkg::*; #(
  parameter int NCOL = GAUGES,
  parameter int FRAC = COEF_FRAC_DEF
) (
  input  logic                     clk_i,
  input  ftc_adv_t                 adv_i,
  input  logic signed [CoefW-1:0]  coef_i [NCOL],
  input  logic signed [GaugeW-1:0] diff_i [NCOL],
  output logic signed [ResW-1:0]   res_o
);

  localparam int SumW = ProdW + $clog2(NCOL) + 1;
  localparam int ShL  = (FRAC < 16) ? 16 - FRAC : 0;
  localparam int ShR  = (FRAC >= 16) ? FRAC - 16 : 0;
  localparam int ExtW = SumW + ShL;
  localparam logic signed [ExtW-1:0] ExtMax = ExtW'(ResMax);
  localparam logic signed [ExtW-1:0] ExtMin = ExtW'(ResMin);

  logic signed [ProdW-1:0] prod_q [NCOL];
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic signed [ExtW-1:0]  scaled;
  logic signed [ResW-1:0]  res_d, res_q;

  for (genvar c = 0; c < NCOL; c++) begin : g_mul
    always_ff @(posedge clk_i) begin
      if (adv_i.prod_en) begin
        prod_q[c] <= ProdW'(coef_i[c]) * ProdW'(diff_i[c]);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int c = 0; c < NCOL; c++) begin
      sum_d = sum_d + SumW'(prod_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  always_comb begin
    scaled = (ExtW'(sum_q) <<< ShL) >>> ShR;
    if (scaled > ExtMax) begin
      res_d = ResMax;
    end else if (scaled < ExtMin) begin
      res_d = ResMin;
    end else begin
      res_d = scaled[ResW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.res_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[bench/tb_six_axis_force_torque_converter.sv]
`timescale 1ns / 100ps
// Self-checking bench for six_axis_force_torque_converter: random and directed
// command words on ftc_in_if, wrench words checked on ftc_out_if against a
// local predictor. Depends on ftc_pkg, ftc_if and the converter RTL.
module tb_six_axis_force_torque_converter;
  import ftc_pkg::*;

  localparam int Axes       = AXES_DEF;
  localparam int CoefFrac   = COEF_FRAC_DEF;
  localparam int TblSize    = Axes * Axes;
  localparam int ShiftDn    = (CoefFrac >= 16) ? CoefFrac - 16 : 0;
  localparam int ShiftUp    = (CoefFrac < 16) ? 16 - CoefFrac : 0;
  localparam int Phases     = 5;
  localparam int MixWords   = 241;
  localparam int TailWords  = 150;
  localparam int DrainCycles = 16;
  localparam int CycleLimit = 200000;
  localparam int MaxLines   = 100;

  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef enum int {COEF_SMALL, COEF_UNIT, COEF_FULL, COEF_EXTREME} coef_mode_e;

  typedef struct packed {
    logic [OpW-1:0]                   opcode;
    logic [IdxW-1:0]                  coef_index;
    logic [CoefW-1:0]                 coef_value;
    logic [GAUGES-1:0][GaugeW-1:0]    gauge;
  } ftc_word_t;

  typedef logic [GAUGES-1:0][ResW-1:0] wrench_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ftc_in_if  in_bus ();
  ftc_out_if out_bus ();

  six_axis_force_torque_converter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic signed [CoefW-1:0]       coef_tbl [TblSize];
  logic [GAUGES-1:0][GaugeW-1:0] bias_vals = '0;
  logic                          bias_armed = 1'b1;

  ftc_word_t cmd_words [$];
  wrench_t   expected_wrenches [$];

  ftc_word_t cur_word;
  logic      nxt_valid;
  logic      quiet_tail;
  int        gap_left;
  int        stall_left;
  int        sent_cnt;
  int        total_words;
  int        res_cnt;
  int        err_cnt;
  int        cyc_cnt;

  function automatic void predict_wrench(input ftc_word_t w);
    logic signed [GaugeW-1:0] d;
    longint                   acc;
    longint                   scaled;
    wrench_t                  res;
    int                       r;
    int                       c;
    case (w.opcode)
      OP_LOAD: begin
        if (w.coef_index < TblSize) coef_tbl[w.coef_index] = w.coef_value;
      end
      OP_REARM: begin
        bias_armed = 1'b1;
      end
      OP_CONVERT: begin
        if (bias_armed) begin
          bias_vals  = w.gauge;
          bias_armed = 1'b0;
        end
        res = '0;
        for (r = 0; r < GAUGES; r++) begin
          if (r < Axes) begin
            acc = 0;
            for (c = 0; c < Axes; c++) begin
              if (c < GAUGES) begin
                d = w.gauge[c] - bias_vals[c];
                acc += longint'(coef_tbl[r*Axes+c]) * longint'(d);
              end
            end
            scaled = (acc >>> ShiftDn) <<< ShiftUp;
            if (scaled > longint'(ResMax)) res[r] = ResMax;
            else if (scaled < longint'(ResMin)) res[r] = ResMin;
            else res[r] = scaled[ResW-1:0];
          end
        end
        expected_wrenches.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MaxLines) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid      <= 1'b0;
      in_bus.opcode     <= '0;
      in_bus.coef_index <= '0;
      in_bus.coef_value <= '0;
      in_bus.gauge_0    <= '0;
      in_bus.gauge_1    <= '0;
      in_bus.gauge_2    <= '0;
      in_bus.gauge_3    <= '0;
      in_bus.gauge_4    <= '0;
      in_bus.gauge_5    <= '0;
      quiet_tail        <= 1'b0;
      gap_left = 0;
      sent_cnt = 0;
    end else begin
      nxt_valid = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        predict_wrench(cur_word);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_words.size() != 0) begin
          cur_word = cmd_words.pop_front();
          in_bus.opcode     <= cur_word.opcode;
          in_bus.coef_index <= cur_word.coef_index;
          in_bus.coef_value <= cur_word.coef_value;
          in_bus.gauge_0    <= cur_word.gauge[0];
          in_bus.gauge_1    <= cur_word.gauge[1];
          in_bus.gauge_2    <= cur_word.gauge[2];
          in_bus.gauge_3    <= cur_word.gauge[3];
          in_bus.gauge_4    <= cur_word.gauge[4];
          in_bus.gauge_5    <= cur_word.gauge[5];
          nxt_valid = 1'b1;
          sent_cnt++;
          quiet_tail <= (sent_cnt + TailWords >= total_words);
          if (sent_cnt + TailWords < total_words && $urandom_range(0, 3) == 0)
            gap_left = $urandom_range(1, 10);
        end
      end
      in_bus.valid <= nxt_valid;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
      res_cnt    = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_wrenches.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with none expected", res_cnt));
        end else begin
          wrench_t want;
          wrench_t got;
          want = expected_wrenches.pop_front();
          got  = {out_bus.torque_z, out_bus.torque_y, out_bus.torque_x,
                  out_bus.force_z, out_bus.force_y, out_bus.force_x};
          if (got[0] !== want[0])
            report_mismatch($sformatf("word %0d force_x %h exp %h", res_cnt, got[0], want[0]));
          if (got[1] !== want[1])
            report_mismatch($sformatf("word %0d force_y %h exp %h", res_cnt, got[1], want[1]));
          if (got[2] !== want[2])
            report_mismatch($sformatf("word %0d force_z %h exp %h", res_cnt, got[2], want[2]));
          if (got[3] !== want[3])
            report_mismatch($sformatf("word %0d torque_x %h exp %h", res_cnt, got[3], want[3]));
          if (got[4] !== want[4])
            report_mismatch($sformatf("word %0d torque_y %h exp %h", res_cnt, got[4], want[4]));
          if (got[5] !== want[5])
            report_mismatch($sformatf("word %0d torque_z %h exp %h", res_cnt, got[5], want[5]));
        end
        res_cnt++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycleLimit) begin
      $display("tb_six_axis_force_torque_converter: FAIL");
      $finish;
    end
  end

  function automatic ftc_word_t rand_word(input logic [OpW-1:0] op);
    ftc_word_t w;
    int        c;
    w.opcode     = op;
    w.coef_index = IdxW'($urandom_range(0, 63));
    w.coef_value = $urandom;
    for (c = 0; c < GAUGES; c++) w.gauge[c] = GaugeW'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic logic [CoefW-1:0] rand_coef(input coef_mode_e mode);
    logic [CoefW-1:0] v;
    case (mode)
      COEF_SMALL: v = int'($urandom_range(0, 131072)) - 65536;
      COEF_UNIT:  v = int'($urandom_range(0, 33554432)) - 16777216;
      COEF_FULL:  v = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = ResMax;
          1:       v = ResMin;
          2:       v = '0;
          3:       v = 32'sd1;
          default: v = -32'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic push_load(input int idx, input logic [CoefW-1:0] val);
    ftc_word_t w;
    w = rand_word(OP_LOAD);
    w.coef_index = IdxW'(idx);
    w.coef_value = val;
    cmd_words.push_back(w);
  endtask

  task automatic push_convert(input logic [GAUGES-1:0][GaugeW-1:0] g);
    ftc_word_t w;
    w = rand_word(OP_CONVERT);
    w.gauge = g;
    cmd_words.push_back(w);
  endtask

  initial begin
    coef_mode_e                    mode;
    logic [GAUGES-1:0][GaugeW-1:0] g;
    logic [GaugeW-1:0]             base;
    int                            i;
    int                            p;
    int                            k;
    int                            c;
    int                            pick;

    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.opcode     = '0;
    in_bus.coef_index = '0;
    in_bus.coef_value = '0;
    in_bus.gauge_0    = '0;
    in_bus.gauge_1    = '0;
    in_bus.gauge_2    = '0;
    in_bus.gauge_3    = '0;
    in_bus.gauge_4    = '0;
    in_bus.gauge_5    = '0;
    out_bus.ready     = 1'b0;
    err_cnt           = 0;
    cyc_cnt           = 0;
    total_words       = 0;

    // full table first: row 0 at the top, row 1 at the bottom
    for (i = 0; i < TblSize; i++) begin
      if (i < Axes) push_load(i, ResMax);
      else if (i < 2 * Axes) push_load(i, ResMin);
      else push_load(i, rand_coef(COEF_UNIT));
    end
    if (TblSize < 64) begin
      push_load(TblSize, ResMax);
      push_load(63, ResMin);
    end
    cmd_words.push_back(rand_word(OpUnused));
    push_convert('0);
    push_convert({GAUGES{16'h7FFF}});
    push_convert({GAUGES{16'h8000}});
    push_convert({3{16'h8000, 16'h7FFF}});
    cmd_words.push_back(rand_word(OP_REARM));
    push_convert({GAUGES{16'h8000}});
    push_convert({GAUGES{16'h7FFF}});
    push_convert({GAUGES{16'h8000}});
    push_convert('0);
    cmd_words.push_back(rand_word(OP_REARM));
    cmd_words.push_back(rand_word(OP_REARM));
    cmd_words.push_back(rand_word(OP_CONVERT));
    cmd_words.push_back(rand_word(OP_CONVERT));
    for (c = 0; c < Axes; c++) push_load(c, '0);
    cmd_words.push_back(rand_word(OP_CONVERT));
    cmd_words.push_back(rand_word(OP_CONVERT));

    for (p = 0; p < Phases; p++) begin
      mode = coef_mode_e'(p % 4);
      base = GaugeW'($urandom_range(0, 65535));
      for (i = 0; i < TblSize; i++) push_load(i, rand_coef(mode));
      cmd_words.push_back(rand_word(OP_REARM));
      for (k = 0; k < MixWords; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          if ($urandom_range(0, 1) == 0) begin
            for (c = 0; c < GAUGES; c++) g[c] = GaugeW'($urandom_range(0, 65535));
          end else begin
            for (c = 0; c < GAUGES; c++)
              g[c] = GaugeW'(int'(base) + int'($urandom_range(0, 511)) - 256);
          end
          push_convert(g);
        end else if (pick < 78) begin
          push_load($urandom_range(0, TblSize - 1), rand_coef(mode));
        end else if (pick < 84) begin
          if (TblSize < 64) push_load($urandom_range(TblSize, 63), $urandom);
          else cmd_words.push_back(rand_word(OpUnused));
        end else if (pick < 92) begin
          cmd_words.push_back(rand_word(OP_REARM));
        end else begin
          cmd_words.push_back(rand_word(OpUnused));
        end
      end
    end
    total_words = cmd_words.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (cmd_words.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (expected_wrenches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_six_axis_force_torque_converter: PASS");
    end else begin
      $display("tb_six_axis_force_torque_converter: FAIL");
    end
    $finish;
  end

endmodule
